### src/shelf_atlas_packer_defines.svh
// Assertion helpers for the shelf atlas packer.
// Both expect clk and rst in scope.
`ifndef SHELF_ATLAS_PACKER_DEFINES_SVH
`define SHELF_ATLAS_PACKER_DEFINES_SVH

// same-cycle implication
`define SAP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sap_pkg.sv
`default_nettype none
package sap_pkg;

  localparam int unsigned DIM_W     = 14;
  localparam int unsigned ORG_W     = 13;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned SIDX_W    = 2;
  localparam int unsigned NSH_CFG_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEETS_IN_USE = 2'd1;

  localparam logic [DIM_W-1:0]     SHEET_SIZE_RST    = 14'd1024;
  localparam logic [NSH_CFG_W-1:0] SHEETS_IN_USE_RST = 3'd4;

  typedef struct packed {
    logic [ORG_W-1:0] base;
    logic [DIM_W-1:0] tall;
    logic [DIM_W-1:0] fill;
  } shelf_t;

endpackage
`default_nettype wire

### src/sap_req_if.sv
`default_nettype none
interface sap_req_if;
  import sap_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;

  modport source (output valid, cmd, rect_width, rect_height, input ready);
  modport sink   (input valid, cmd, rect_width, rect_height, output ready);
endinterface
`default_nettype wire

### src/sap_res_if.sv
`default_nettype none
interface sap_res_if;
  import sap_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SIDX_W-1:0] sheet_index;
  logic [ORG_W-1:0]  origin_x;
  logic [ORG_W-1:0]  origin_y;

  modport source (output valid, status, sheet_index, origin_x, origin_y, input ready);
  modport sink   (input valid, status, sheet_index, origin_x, origin_y, output ready);
endinterface
`default_nettype wire

### src/sap_cfg_if.sv
`default_nettype none
interface sap_cfg_if;
  import sap_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/sap_shelf_mem.sv
`default_nettype none
module sap_shelf_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output sap_pkg::shelf_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sap_pkg::shelf_t wr_data
);
  import sap_pkg::*;

  shelf_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### src/shelf_atlas_packer.sv
// Shelf first-fit atlas packer, one result word per request word.
// Clear, and insert with no sheets in use, go straight to S_DONE. Insert scans in S_SCAN:
//   per sheet it reads the shelves in order and takes the first that fits, else opens a
//   new shelf if there is room and a free slot, else moves on to the next sheet.
// A new request is taken only in S_IDLE; a result held at the output stalls in S_DONE.
// Reset (rst, synchronous): no shelves, zero used height, sheet_size 1024, sheets_in_use 4.
`default_nettype none
`include "shelf_atlas_packer_defines.svh"
module shelf_atlas_packer #(
  parameter int unsigned MAX_SHEETS  = 4,
  parameter int unsigned MAX_SHELVES = 64,
  parameter int unsigned MAX_EDGE    = 8192
) (
  input  logic clk,
  input  logic rst,
  sap_req_if.sink   req,
  sap_res_if.source res,
  sap_cfg_if.sink   cfg
);
  import sap_pkg::*;

  localparam int unsigned DEPTH = MAX_SHEETS * MAX_SHELVES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (MAX_SHEETS > 1) ? $clog2(MAX_SHEETS) : 1;
  localparam int unsigned KW    = $clog2(MAX_SHELVES + 1);
  localparam int unsigned NS_W  = $clog2(MAX_SHEETS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  // configuration
  logic [DIM_W-1:0]     sheet_size;
  logic [NSH_CFG_W-1:0] sheets_in_use;

  // per-sheet bookkeeping, small enough for flops
  logic [KW-1:0]    shelf_count       [MAX_SHEETS];
  logic [DIM_W-1:0] sheet_used_height [MAX_SHEETS];

  // search state
  state_t           state;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [SW-1:0]    s;          // sheet under search
  logic [KW-1:0]    k;          // next shelf to read
  logic [AW-1:0]    base_addr;  // first memory entry of sheet s
  logic             chk_valid;  // rd_data holds a shelf to test this cycle
  logic [AW-1:0]    chk_addr;
  logic             full;       // some sheet wanted a shelf but had no slot

  // result waiting for the output register
  logic [STAT_W-1:0] rs_status;
  logic [SIDX_W-1:0] rs_sheet;
  logic [ORG_W-1:0]  rs_x;
  logic [ORG_W-1:0]  rs_y;

  // memory port
  logic   rd_en;
  logic   wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  shelf_t rd_data;
  shelf_t wr_data;

  // scan-cycle decode
  logic [DIM_W-1:0] size;
  logic [NS_W-1:0]  nsheets;
  logic [KW-1:0]    cnt_cur;
  logic [DIM_W-1:0] used_cur;
  logic [DIM_W:0]   fill_sum;
  logic [DIM_W:0]   used_sum;
  logic             hit;
  logic             more;
  logic             room;
  logic             at_cap;
  logic             last_sheet;
  logic             full_now;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    // oversize sheet and sheet count clamp to the build limits
    size     = (32'(sheet_size) > MAX_EDGE) ? DIM_W'(MAX_EDGE) : sheet_size;
    nsheets  = (32'(sheets_in_use) > MAX_SHEETS) ? NS_W'(MAX_SHEETS)
                                                  : NS_W'(sheets_in_use);
    cnt_cur  = shelf_count[s];
    used_cur = sheet_used_height[s];
    fill_sum = {1'b0, rd_data.fill} + {1'b0, w};
    used_sum = {1'b0, used_cur} + {1'b0, h};

    // existing shelf takes it: tall enough and width still inside the sheet
    hit  = chk_valid && (h <= rd_data.tall) && (fill_sum <= {1'b0, size});
    more = (k < cnt_cur);
    // a new shelf would fit above the last one
    room       = (w <= size) && (used_sum <= {1'b0, size});
    at_cap     = (32'(cnt_cur) >= MAX_SHELVES);
    last_sheet = !((32'(s) + 32'd1) < 32'(nsheets));
    full_now   = full || (room && at_cap);

    rd_addr = AW'(32'(base_addr) + 32'(k));
    rd_en   = (state == S_SCAN) && !hit && more;
    wr_en   = (state == S_SCAN) && (hit || (!more && room && !at_cap));
    // when the shelves are exhausted k equals the count, so rd_addr is the new slot
    wr_addr = hit ? chk_addr : rd_addr;
    if (hit) begin
      wr_data.base = rd_data.base;
      wr_data.tall = rd_data.tall;
      wr_data.fill = fill_sum[DIM_W-1:0];
    end else begin
      wr_data.base = used_cur[ORG_W-1:0];
      wr_data.tall = h;
      wr_data.fill = w;
    end
  end

  sap_shelf_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_shelf_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res.valid     <= 1'b0;
      chk_valid     <= 1'b0;
      full          <= 1'b0;
      sheet_size    <= SHEET_SIZE_RST;
      sheets_in_use <= SHEETS_IN_USE_RST;
      for (int i = 0; i < MAX_SHEETS; i++) begin
        shelf_count[i]       <= '0;
        sheet_used_height[i] <= '0;
      end
    end else begin
      // config words, taken only while idle by contract
      if (cfg.valid) begin
        case (cfg.index)
          REG_SHEET_SIZE:    sheet_size    <= cfg.data;
          REG_SHEETS_IN_USE: sheets_in_use <= cfg.data[NSH_CFG_W-1:0];
          default: ;
        endcase
      end

      // S_DONE reloads the output register itself
      if (res.valid && res.ready && state != S_DONE) begin
        res.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            w         <= req.rect_width;
            h         <= req.rect_height;
            s         <= '0;
            k         <= '0;
            base_addr <= '0;
            chk_valid <= 1'b0;
            full      <= 1'b0;
            rs_sheet  <= '0;
            rs_x      <= '0;
            rs_y      <= '0;
            if (req.cmd == CMD_CLEAR) begin
              // clear every sheet, in use or not
              for (int i = 0; i < MAX_SHEETS; i++) begin
                shelf_count[i]       <= '0;
                sheet_used_height[i] <= '0;
              end
              rs_status <= ST_OK;
              state     <= S_DONE;
            end else if (nsheets == '0) begin
              rs_status <= ST_NO_ROOM;
              state     <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (hit) begin
            chk_valid <= 1'b0;
            rs_status <= ST_OK;
            rs_sheet  <= SIDX_W'(s);
            rs_x      <= rd_data.fill[ORG_W-1:0];
            rs_y      <= rd_data.base;
            state     <= S_DONE;
          end else if (more) begin
            // stream the next shelf; its data is tested next cycle
            chk_valid <= 1'b1;
            chk_addr  <= rd_addr;
            k         <= k + KW'(1);
          end else begin
            chk_valid <= 1'b0;
            if (room && !at_cap) begin
              shelf_count[s]       <= cnt_cur + KW'(1);
              sheet_used_height[s] <= used_sum[DIM_W-1:0];
              rs_status            <= ST_OK;
              rs_sheet             <= SIDX_W'(s);
              rs_x                 <= '0;
              rs_y                 <= used_cur[ORG_W-1:0];
              state                <= S_DONE;
            end else if (last_sheet) begin
              rs_status <= full_now ? ST_FULL : ST_NO_ROOM;
              state     <= S_DONE;
            end else begin
              full      <= full_now;
              s         <= s + SW'(1);
              k         <= '0;
              base_addr <= AW'(32'(base_addr) + MAX_SHELVES);
            end
          end
        end

        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.status      <= rs_status;
            res.sheet_index <= rs_sheet;
            res.origin_x    <= rs_x;
            res.origin_y    <= rs_y;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // a taken request always starts a search or a result
  `SAP_CHECK_NEXT(a_req_leaves_idle, req.valid && req.ready, state != S_IDLE, "request not processed")
  // read cursor never passes the sheet's shelf count
  `SAP_CHECK(a_cursor_in_range, state == S_SCAN, k <= cnt_cur, "shelf cursor beyond count")
  // one memory access per cycle
  `SAP_CHECK(a_single_port, wr_en, !rd_en, "memory read and write collide")
  // a released result lands in the output register
  `SAP_CHECK_NEXT(a_result_out, state == S_DONE && (!res.valid || res.ready), res.valid, "result lost")

endmodule
`default_nettype wire

### sim/tb_shelf_atlas_packer.sv
`default_nettype none
module tb_shelf_atlas_packer;
  import sap_pkg::*;

  localparam int unsigned SHEETS  = 4;
  localparam int unsigned SHELVES = 64;
  localparam int unsigned EDGE    = 8192;

  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one result word as the block reports it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIDX_W-1:0] sheet;
    logic [ORG_W-1:0]  x;
    logic [ORG_W-1:0]  y;
  } placement_t;

  logic clk = 1'b0;
  logic rst;

  sap_req_if req ();
  sap_res_if res ();
  sap_cfg_if cfg ();

  shelf_atlas_packer #(
    .MAX_SHEETS (SHEETS),
    .MAX_SHELVES(SHELVES),
    .MAX_EDGE   (EDGE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Packing model: own copy of registers and shelf store
  // ---------------------------------------------------------------------
  int unsigned      edge_reg;      // sheet_size as written (14 bits)
  logic [2:0]       sheets_reg;    // sheets_in_use as written
  int unsigned      n_shelves [SHEETS];
  int unsigned      used_h    [SHEETS];
  int unsigned      shelf_y   [SHEETS*SHELVES];
  int unsigned      shelf_h   [SHEETS*SHELVES];
  int unsigned      shelf_x   [SHEETS*SHELVES];

  placement_t  expected_places[$];
  placement_t  head_place;
  int unsigned mismatches;

  // stall knobs, percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;         // long receiver hold-off, in cycles

  function automatic void empty_sheets();
    for (int s = 0; s < SHEETS; s++) begin
      n_shelves[s] = 0;
      used_h[s]    = 0;
    end
    for (int i = 0; i < SHEETS*SHELVES; i++) begin
      shelf_y[i] = 0;
      shelf_h[i] = 0;
      shelf_x[i] = 0;
    end
  endfunction

  // First-fit over sheets, then shelves; opens a new shelf when none fits.
  function automatic placement_t place_rect(logic cmd, logic [DIM_W-1:0] w_in,
                                            logic [DIM_W-1:0] h_in);
    placement_t  p;
    int unsigned w, h, lim, nsh, cnt, i, s, k;
    bit          full, done;
    p    = '0;
    w    = {18'd0, w_in};
    h    = {18'd0, h_in};
    lim  = (edge_reg > EDGE) ? EDGE : edge_reg;
    nsh  = (sheets_reg > SHEETS) ? SHEETS : {29'd0, sheets_reg};
    full = 1'b0;
    done = 1'b0;
    if (cmd == CMD_CLEAR) begin
      // clear hits every sheet, searched or not
      empty_sheets();
      p.status = ST_OK;
      done     = 1'b1;
    end
    for (s = 0; s < nsh && !done; s++) begin
      cnt = (n_shelves[s] > SHELVES) ? SHELVES : n_shelves[s];
      for (k = 0; k < cnt && !done; k++) begin
        i = s*SHELVES + k;
        if (h <= shelf_h[i] && shelf_x[i] + w <= lim) begin
          p.status   = ST_OK;
          p.sheet    = s[SIDX_W-1:0];
          p.x        = shelf_x[i][ORG_W-1:0];
          p.y        = shelf_y[i][ORG_W-1:0];
          shelf_x[i] = shelf_x[i] + w;
          done       = 1'b1;
        end
      end
      // too wide never opens a shelf
      if (!done && w <= lim && used_h[s] + h <= lim) begin
        if (cnt >= SHELVES) begin
          full = 1'b1;
        end else begin
          i            = s*SHELVES + cnt;
          shelf_y[i]   = used_h[s];
          shelf_h[i]   = h;
          shelf_x[i]   = w;
          n_shelves[s] = cnt + 1;
          used_h[s]    = used_h[s] + h;
          p.status     = ST_OK;
          p.sheet      = s[SIDX_W-1:0];
          p.x          = '0;
          p.y          = shelf_y[i][ORG_W-1:0];   // 8192 wraps to zero
          done         = 1'b1;
        end
      end
    end
    if (!done) p.status = full ? ST_FULL : ST_NO_ROOM;
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: ready pattern and scoreboard
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (expected_places.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: st=%0d sheet=%0d x=%0d y=%0d",
                   res.status, res.sheet_index, res.origin_x, res.origin_y);
      end else begin
        head_place = expected_places.pop_front();
        if (res.status !== head_place.status || res.sheet_index !== head_place.sheet ||
            res.origin_x !== head_place.x || res.origin_y !== head_place.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want st=%0d sheet=%0d x=%0d y=%0d, got st=%0d sheet=%0d x=%0d y=%0d",
                     head_place.status, head_place.sheet, head_place.x, head_place.y,
                     res.status, res.sheet_index, res.origin_x, res.origin_y);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side helpers; every task starts and ends right after a rising edge
  // ---------------------------------------------------------------------
  task automatic send_word(logic cmd, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.cmd         <= cmd;
    req.rect_width  <= w;
    req.rect_height <= h;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_places.insert(expected_places.size(), place_rect(cmd, w, h));
  endtask

  // sender goes quiet until every result word is back
  task automatic drain_results();
    req.valid <= 1'b0;
    while (expected_places.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_SHEET_SIZE)
      edge_reg = {18'd0, val};
    else if (idx == REG_SHEETS_IN_USE)
      sheets_reg = val[2:0];
    @(posedge clk);
  endtask

  task automatic set_config(logic [DIM_W-1:0] edge_px, logic [2:0] n_sheets);
    drain_results();
    write_reg(REG_SHEET_SIZE, edge_px);
    write_reg(REG_SHEETS_IN_USE, {11'd0, n_sheets});
  endtask

  // mostly small against the sheet, some edge-sized, some anything
  function automatic logic [DIM_W-1:0] rand_dim(int unsigned edge_px);
    int unsigned lim, r;
    lim = (edge_px > EDGE) ? EDGE : edge_px;
    case ($urandom_range(0, 19))
      0, 1:    r = $urandom_range(0, EDGE);
      2:       r = lim;
      3:       r = (lim == EDGE) ? EDGE : lim + 1;
      4, 5, 6: r = $urandom_range(0, lim);
      default: r = $urandom_range(0, lim/4 + 1);
    endcase
    return r[DIM_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    // reset defaults: sheet size 1024, four sheets
    send_word(CMD_INSERT, 14'd0, 14'd0);        // zero-height shelf at row 0
    send_word(CMD_INSERT, 14'd1024, 14'd1024);  // fills sheet 0 to the top
    send_word(CMD_INSERT, 14'd1025, 14'd1);     // too wide for any sheet
    send_word(CMD_INSERT, 14'd10, 14'd10);      // spills to sheet 1
    send_word(CMD_INSERT, 14'd0, 14'd1024);     // zero width lands at x = edge
    send_word(CMD_CLEAR, 14'd8192, 14'd8192);
    send_word(CMD_INSERT, 14'd10, 14'd10);      // back on sheet 0 after clear

    // largest sheet, one sheet searched
    set_config(14'd8192, 3'd1);
    send_word(CMD_CLEAR, 14'd0, 14'd0);
    send_word(CMD_INSERT, 14'd8192, 14'd8192);
    send_word(CMD_INSERT, 14'd0, 14'd0);        // x of 8192 wraps to 0
    send_word(CMD_INSERT, 14'd1, 14'd0);        // new shelf at row 8192, wraps
    send_word(CMD_INSERT, 14'd1, 14'd1);        // no room

    // nothing searched
    set_config(14'd8192, 3'd0);
    send_word(CMD_INSERT, 14'd1, 14'd1);

    // edge above the max and sheet count above the max both clamp
    set_config(14'h3FFF, 3'd7);
    send_word(CMD_CLEAR, 14'd0, 14'd0);
    send_word(CMD_INSERT, 14'd8192, 14'd1);
    send_word(CMD_INSERT, 14'd5000, 14'd2);

    // shrink the sheet with shelves still in place
    set_config(14'd1, 3'd7);
    send_word(CMD_INSERT, 14'd1, 14'd1);
    send_word(CMD_INSERT, 14'd0, 14'd0);

    // write to an index with no register: config must hold
    drain_results();
    write_reg(REG_UNUSED, 14'h3FFF);
    send_word(CMD_INSERT, 14'd1, 14'd1);
    send_word(CMD_CLEAR, 14'd0, 14'd0);
  endtask

  // stack 64 shelves in one sheet, then ask for one more
  task automatic test_store_full();
    set_config(14'd128, 3'd1);
    send_word(CMD_CLEAR, 14'd0, 14'd0);
    repeat (SHELVES) send_word(CMD_INSERT, 14'd128, 14'($urandom_range(0, 2)));
    send_word(CMD_INSERT, 14'd128, 14'd0);      // would open a shelf: store full
    send_word(CMD_INSERT, 14'd0, 14'd0);
    send_word(CMD_INSERT, 14'd129, 14'd1);      // too wide: plain no room
    // open sheet 1 while sheet 0 stays packed
    set_config(14'd128, 3'd2);
    send_word(CMD_INSERT, 14'd128, 14'd1);
    send_word(CMD_INSERT, 14'd128, 14'($urandom_range(0, 1)));
    send_word(CMD_CLEAR, 14'd0, 14'd0);
  endtask

  // phases of random inserts, each under a fresh config, shelves kept or not
  task automatic test_random_mix(int unsigned n_words);
    int unsigned     left, chunk;
    logic [DIM_W-1:0] edge_px;
    logic [2:0]       n_sheets;
    left = n_words;
    while (left != 0) begin
      chunk = $urandom_range(20, 45);
      if (chunk > left) chunk = left;
      case ($urandom_range(0, 7))
        0:       edge_px = 14'd1;
        1:       edge_px = 14'd16;
        2:       edge_px = 14'd64;
        3:       edge_px = 14'd256;
        4:       edge_px = 14'd1024;
        5:       edge_px = 14'd8192;
        6:       edge_px = 14'($urandom_range(1, 8192));
        default: edge_px = 14'($urandom_range(8193, 16383));
      endcase
      n_sheets = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                            : 3'($urandom_range(0, 7));
      set_config(edge_px, n_sheets);
      if ($urandom_range(0, 1) == 0)
        send_word(CMD_CLEAR, 14'($urandom_range(0, EDGE)), 14'($urandom_range(0, EDGE)));
      repeat (chunk) begin
        if ($urandom_range(99) < 4)
          send_word(CMD_CLEAR, rand_dim(edge_px), rand_dim(edge_px));
        else
          send_word(CMD_INSERT, rand_dim(edge_px), rand_dim(edge_px));
      end
      left = left - chunk;
    end
  endtask

  // receiver goes dark for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    set_config(14'd256, 3'd4);
    send_idle_pct = 0;
    hold_left    <= 600;
    repeat (24) send_word(CMD_INSERT, rand_dim(256), rand_dim(256));
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.cmd         = CMD_INSERT;
    req.rect_width  = '0;
    req.rect_height = '0;
    res.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_SHEET_SIZE;
    cfg.data        = '0;
    hold_left       = 0;
    mismatches      = 0;
    edge_reg        = {18'd0, SHEET_SIZE_RST};
    sheets_reg      = SHEETS_IN_USE_RST;
    empty_sheets();

    // sender idles 36 %, receiver stalls 80 %
    send_idle_pct  = 36;
    recv_stall_pct = 80;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_random_mix(140);

    // swap: sender idles 80 %, receiver stalls 36 %
    send_idle_pct  = 80;
    recv_stall_pct = 36;
    test_random_mix(140);
    test_backpressure();

    // full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(170);

    // wait out the longest search so stray words get caught
    drain_results();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_places.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
